// File: sv/aekd_pkg.sv
// Package with the types, codes and key lookup functions of the ANSI escape key decoder.
package aekd_pkg;

    localparam int unsigned SKIP_LIMIT = 8;
    localparam int unsigned SKIP_W = 4;

    localparam logic [7:0] CODE_ESC = 8'd27;
    localparam logic [7:0] CH_BRACKET = 8'h5B;
    localparam logic [7:0] CH_O = 8'h4F;
    localparam logic [7:0] CH_A = 8'h41;
    localparam logic [7:0] CH_B = 8'h42;
    localparam logic [7:0] CH_C = 8'h43;
    localparam logic [7:0] CH_D = 8'h44;
    localparam logic [7:0] CH_H = 8'h48;
    localparam logic [7:0] CH_F = 8'h46;
    localparam logic [7:0] CH_I = 8'h49;
    localparam logic [7:0] CH_G = 8'h47;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_AT = 8'h40;
    localparam logic [7:0] CH_SKIP_TOP = 8'h40;

    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_KEY = 2'd1;
    localparam logic [1:0] KIND_END = 2'd2;

    localparam logic [3:0] K_UP = 4'd0;
    localparam logic [3:0] K_DOWN = 4'd1;
    localparam logic [3:0] K_RIGHT = 4'd2;
    localparam logic [3:0] K_LEFT = 4'd3;
    localparam logic [3:0] K_HOME = 4'd4;
    localparam logic [3:0] K_END = 4'd5;
    localparam logic [3:0] K_PGUP = 4'd6;
    localparam logic [3:0] K_PGDN = 4'd7;
    localparam logic [3:0] K_INSERT = 4'd8;
    localparam logic [3:0] K_DELETE = 4'd9;

    typedef enum logic [4:0] {
        PH_IDLE   = 5'b00001,
        PH_ESC    = 5'b00010,
        PH_INTRO  = 5'b00100,
        PH_NUMBER = 5'b01000,
        PH_SKIP   = 5'b10000
    } phase_t;

    typedef struct packed {
        phase_t            phase;
        logic              intro_is_bracket;
        logic [7:0]        param_number;
        logic [SKIP_W-1:0] skip_count;
    } parse_state_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] kind;
        logic [7:0] value;
    } result_t;

    typedef struct packed {
        logic       hit;
        logic [3:0] key;
    } key_match_t;

    function automatic key_match_t letter_key(input logic [7:0] b);
        key_match_t m;
        m.hit = 1'b1;
        case (b)
            CH_A:    m.key = K_UP;
            CH_B:    m.key = K_DOWN;
            CH_C:    m.key = K_RIGHT;
            CH_D:    m.key = K_LEFT;
            CH_H:    m.key = K_HOME;
            CH_F:    m.key = K_END;
            default:
            begin
                m.hit = 1'b0;
                m.key = K_UP;
            end
        endcase
        return m;
    endfunction

    function automatic key_match_t number_final(input logic [7:0] b, input logic [7:0] n);
        key_match_t m;
        m = letter_key(b);
        if (!m.hit && (b == CH_TILDE || b == CH_CARET || b == CH_DOLLAR || b == CH_AT))
        begin
            m.hit = 1'b1;
            case (n)
                8'd1, 8'd7: m.key = K_HOME;
                8'd2:       m.key = K_INSERT;
                8'd3:       m.key = K_DELETE;
                8'd4, 8'd8: m.key = K_END;
                8'd5:       m.key = K_PGUP;
                8'd6:       m.key = K_PGDN;
                default:
                begin
                    m.hit = 1'b0;
                    m.key = K_UP;
                end
            endcase
        end
        return m;
    endfunction

endpackage

// File: sv/aekd_if.sv
// Request channel interfaces for the key bytes and the decoded results.
interface aekd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] key_byte;
    logic       end_of_input;

    modport source(output valid, output key_byte, output end_of_input, input ready);
    modport sink(input valid, input key_byte, input end_of_input, output ready);
endinterface

interface aekd_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] result_kind;
    logic [7:0] result_value;

    modport source(output valid, output result_kind, output result_value, input ready);
    modport sink(input valid, input result_kind, input result_value, output ready);
endinterface

// File: sv/aekd_decode.sv
// Next-state and result logic of the escape sequence parser for one key byte.
module aekd_decode (
    input  aekd_pkg::parse_state_t state,
    input  logic [7:0]             key_byte,
    input  logic                   end_of_input,
    output aekd_pkg::parse_state_t state_next,
    output aekd_pkg::result_t      result
);

    aekd_pkg::key_match_t      direct_match;
    aekd_pkg::key_match_t      final_match;
    logic [11:0]               number_sum;
    logic [aekd_pkg::SKIP_W-1:0] skip_inc;
    logic                      is_digit;

    always_comb
    begin
        direct_match = aekd_pkg::letter_key(key_byte);
        final_match = aekd_pkg::number_final(key_byte, state.param_number);
        is_digit = (key_byte inside {[aekd_pkg::CH_ZERO:aekd_pkg::CH_NINE]});
        number_sum = {1'b0, state.param_number, 3'b000} + {3'b000, state.param_number, 1'b0}
            + {4'd0, key_byte - aekd_pkg::CH_ZERO};
        skip_inc = state.skip_count + 1'b1;

        state_next = state;
        result = '{valid: 1'b0, kind: aekd_pkg::KIND_BYTE, value: 8'd0};

        case (state.phase)
            aekd_pkg::PH_ESC:
            begin
                if (end_of_input || (key_byte != aekd_pkg::CH_BRACKET && key_byte != aekd_pkg::CH_O))
                begin
                    result = '{valid: 1'b1, kind: aekd_pkg::KIND_BYTE, value: aekd_pkg::CODE_ESC};
                    state_next.phase = aekd_pkg::PH_IDLE;
                end
                else
                begin
                    state_next.intro_is_bracket = (key_byte == aekd_pkg::CH_BRACKET);
                    state_next.phase = aekd_pkg::PH_INTRO;
                end
            end
            aekd_pkg::PH_INTRO:
            begin
                state_next.phase = aekd_pkg::PH_IDLE;
                if (end_of_input)
                begin
                    result = '{valid: 1'b1, kind: aekd_pkg::KIND_BYTE, value: aekd_pkg::CODE_ESC};
                end
                else if (direct_match.hit)
                begin
                    result = '{valid: 1'b1, kind: aekd_pkg::KIND_KEY,
                               value: {4'd0, direct_match.key}};
                end
                else if (state.intro_is_bracket && key_byte == aekd_pkg::CH_I)
                begin
                    result = '{valid: 1'b1, kind: aekd_pkg::KIND_KEY,
                               value: {4'd0, aekd_pkg::K_PGUP}};
                end
                else if (state.intro_is_bracket && key_byte == aekd_pkg::CH_G)
                begin
                    result = '{valid: 1'b1, kind: aekd_pkg::KIND_KEY,
                               value: {4'd0, aekd_pkg::K_PGDN}};
                end
                else if (is_digit)
                begin
                    state_next.param_number = key_byte - aekd_pkg::CH_ZERO;
                    state_next.phase = aekd_pkg::PH_NUMBER;
                end
                else
                begin
                    result = '{valid: 1'b1, kind: aekd_pkg::KIND_BYTE, value: aekd_pkg::CODE_ESC};
                end
            end
            aekd_pkg::PH_NUMBER:
            begin
                if (end_of_input)
                begin
                    result = '{valid: 1'b1, kind: aekd_pkg::KIND_BYTE, value: aekd_pkg::CODE_ESC};
                    state_next.phase = aekd_pkg::PH_IDLE;
                end
                else if (is_digit)
                begin
                    state_next.param_number = (number_sum > 12'd255) ? 8'd255 : number_sum[7:0];
                end
                else if (key_byte < aekd_pkg::CH_SKIP_TOP)
                begin
                    state_next.skip_count = '0;
                    state_next.phase = aekd_pkg::PH_SKIP;
                end
                else
                begin
                    state_next.phase = aekd_pkg::PH_IDLE;
                    if (final_match.hit)
                    begin
                        result = '{valid: 1'b1, kind: aekd_pkg::KIND_KEY,
                                   value: {4'd0, final_match.key}};
                    end
                    else
                    begin
                        result = '{valid: 1'b1, kind: aekd_pkg::KIND_BYTE,
                                   value: aekd_pkg::CODE_ESC};
                    end
                end
            end
            aekd_pkg::PH_SKIP:
            begin
                if (end_of_input)
                begin
                    result = '{valid: 1'b1, kind: aekd_pkg::KIND_BYTE, value: aekd_pkg::CODE_ESC};
                    state_next.phase = aekd_pkg::PH_IDLE;
                end
                else
                begin
                    state_next.skip_count = skip_inc;
                    if (key_byte >= aekd_pkg::CH_SKIP_TOP)
                    begin
                        state_next.phase = aekd_pkg::PH_IDLE;
                        if (final_match.hit)
                        begin
                            result = '{valid: 1'b1, kind: aekd_pkg::KIND_KEY,
                                       value: {4'd0, final_match.key}};
                        end
                        else
                        begin
                            result = '{valid: 1'b1, kind: aekd_pkg::KIND_BYTE,
                                       value: aekd_pkg::CODE_ESC};
                        end
                    end
                    else if (skip_inc >= aekd_pkg::SKIP_W'(aekd_pkg::SKIP_LIMIT))
                    begin
                        state_next.phase = aekd_pkg::PH_IDLE;
                        result = '{valid: 1'b1, kind: aekd_pkg::KIND_BYTE,
                                   value: aekd_pkg::CODE_ESC};
                    end
                end
            end
            default:
            begin
                state_next.phase = aekd_pkg::PH_IDLE;
                if (end_of_input)
                begin
                    result = '{valid: 1'b1, kind: aekd_pkg::KIND_END, value: 8'd0};
                end
                else if (key_byte != aekd_pkg::CODE_ESC)
                begin
                    result = '{valid: 1'b1, kind: aekd_pkg::KIND_BYTE, value: key_byte};
                end
                else
                begin
                    state_next.phase = aekd_pkg::PH_ESC;
                end
            end
        endcase
    end

endmodule

// File: sv/ansi_escape_key_decoder_top.sv
// Top level of the ANSI escape key decoder: input register, parser state and result register.
//
// The decoder takes one keyboard byte per request and gives at most one result per byte:
// a plain byte, a special key (arrows, home, end, page up and down, insert, delete) or
// an end-of-input marker. Bytes that are part of an escape sequence give no result until
// the sequence ends; an unmatched or cut-off sequence gives ESC (27) and its bytes are
// dropped. A byte is held in the input register once it is taken and is decoded on its way
// from there to the result register, from which its result is offered, and the block takes
// one byte every cycle while results are taken as they come.
module ansi_escape_key_decoder_top (
    input  logic             clk,
    input  logic             rst_n,
    aekd_in_if.sink          key_in,
    aekd_out_if.source       key_out
);

    logic                   in_valid_reg;
    logic [7:0]             in_byte_reg;
    logic                   in_eoi_reg;
    aekd_pkg::parse_state_t state_reg;
    aekd_pkg::parse_state_t state_next;
    aekd_pkg::result_t      step_result;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [1:0]             out_kind_reg;
    logic [7:0]             out_value_reg;
    logic                   advance;
    logic                   in_take;

    assign advance = in_valid_reg && (!out_valid_reg || key_out.ready);
    assign key_in.ready = !in_valid_reg || advance;
    assign in_take = key_in.valid && key_in.ready;

    aekd_decode u_decode (
        .state        (state_reg),
        .key_byte     (in_byte_reg),
        .end_of_input (in_eoi_reg),
        .state_next   (state_next),
        .result       (step_result)
    );

    always_comb
    begin
        if (advance && step_result.valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (key_out.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg <= '{phase: aekd_pkg::PH_IDLE, intro_is_bracket: 1'b0,
                           param_number: 8'd0, skip_count: '0};
        end
        else
        begin
            if (key_in.ready)
            begin
                in_valid_reg <= key_in.valid;
            end
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= key_in.key_byte;
            in_eoi_reg <= key_in.end_of_input;
        end
        if (advance && step_result.valid)
        begin
            out_kind_reg <= step_result.kind;
            out_value_reg <= step_result.value;
        end
    end

    assign key_out.valid = out_valid_reg;
    assign key_out.result_kind = out_kind_reg;
    assign key_out.result_value = out_value_reg;

`ifndef SYNTHESIS
    a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg.phase))
        else $error("Parser phase is not one-hot.");

    a_skip_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase == aekd_pkg::PH_SKIP
        |-> state_reg.skip_count < aekd_pkg::SKIP_W'(aekd_pkg::SKIP_LIMIT))
        else $error("Skip count reached the limit without leaving the skip phase.");

    a_key_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        key_out.valid && key_out.result_kind == aekd_pkg::KIND_KEY
        |-> key_out.result_value <= {4'd0, aekd_pkg::K_DELETE})
        else $error("Special key result carries an unknown key code.");

    a_end_only_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
        advance && step_result.valid && step_result.kind == aekd_pkg::KIND_END
        |-> state_reg.phase == aekd_pkg::PH_IDLE && step_result.value == 8'd0)
        else $error("End result produced inside an escape sequence.");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !key_out.ready |=> out_valid_reg && $stable(out_value_reg)
        && $stable(out_kind_reg))
        else $error("Pending result was overwritten before it was taken.");
`endif

endmodule
